// ===== rtl/cmst_pkg.sv =====
package cmst_pkg;

    // Default map size in 32-bit words (pairs of start words)
    localparam int unsigned MAP_WORDS_DEF = 64;

    localparam logic [31:0] END_MARK     = 32'hFFFF_FFFF;
    localparam int unsigned SECTOR_SHIFT = 9;
    localparam int unsigned SECTOR_W     = 32 - SECTOR_SHIFT;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    // Map select codes
    localparam logic MAP_SAVE = 1'b0;
    localparam logic MAP_ROM  = 1'b1;

endpackage

// ===== rtl/cluster_map_sector_translate_top.sv =====
// Channel  | Direction | Handshake                      | Payload
// ---------+-----------+--------------------------------+------------------------------------
// in       | to block  | i_in_valid / o_in_ready        | operation, map_select, word_index,
//          |           |                                | word_value, byte_address
// out      | from blk  | o_out_valid / i_out_ready      | sd_sector
//
// A load item gives no result; the next item may follow at once.
// A translate walks one map pair per cycle through the single read port of the even/odd
// word memories, then forms the result in S_FIN; no new item is taken until the
// result is registered and the block is back in S_IDLE.
// The walk ends early at the end marker. Reset clears only control state; the maps hold
// nothing defined until loaded. A result that waits on i_out_ready holds the walk in S_FIN.
module cluster_map_sector_translate_top
    import cmst_pkg::*;
#(
    parameter int unsigned MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic        i_map_select,
    input  logic [5:0]  i_word_index,
    input  logic [31:0] i_word_value,
    input  logic [31:0] i_byte_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_sd_sector
);

    // Complete pairs walked, and rows per memory (an odd trailing word gets a row)
    localparam int unsigned NPAIRS     = MAP_WORDS / 2;
    localparam int unsigned PAIR_DEPTH = (MAP_WORDS + 1) / 2;
    localparam int unsigned PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int unsigned PAIR_W     = $clog2(NPAIRS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    // Even words (logical starts) and odd words (SD starts), one array per map select
    logic [31:0] r_mem_even [2][PAIR_DEPTH];
    logic [31:0] r_mem_odd  [2][PAIR_DEPTH];

    t_state              r_state;
    logic [PAIR_W-1:0]   r_pair;
    logic                r_first;
    logic                r_sel;
    logic [SECTOR_W-1:0] r_sector;
    logic [31:0]         r_even;
    logic [31:0]         r_odd;
    logic [31:0]         r_sd_base;
    logic [31:0]         r_log_base;
    logic                r_out_valid;
    logic [31:0]         r_out;

    logic               in_acc;
    logic               wr_en;
    logic [PAIR_AW-1:0] wr_addr;
    logic [PAIR_AW+5:0] wr_addr_ext;
    logic               rd_en;
    logic               rd_sel;
    logic [PAIR_AW-1:0] rd_addr;
    logic [31:0]        sector32;
    logic               walk_end;
    logic               walk_take;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_sd_sector = r_out;

    // Drop loads that fall past the map
    assign wr_addr_ext = {{(PAIR_AW + 1){1'b0}}, i_word_index[5:1]};
    assign wr_addr     = wr_addr_ext[PAIR_AW-1:0];
    assign wr_en       = in_acc && (i_operation == OP_LOAD)
                         && (32'(i_word_index) < 32'(MAP_WORDS));

    assign sector32 = {{SECTOR_SHIFT{1'b0}}, r_sector};

    // Walk stops on the end marker or after the last complete pair
    assign walk_end  = (r_even == END_MARK) || (32'(r_pair) == 32'(NPAIRS));
    // Pair 0 seeds the bases whatever it holds
    assign walk_take = r_first || ((r_even != END_MARK) && (r_even < sector32));

    always_comb begin
        rd_en   = 1'b0;
        rd_sel  = r_sel;
        rd_addr = r_pair[PAIR_AW-1:0];
        if (in_acc && (i_operation == OP_XLATE)) begin
            rd_en   = 1'b1;
            rd_sel  = i_map_select;
            rd_addr = '0;
        end else if ((r_state == S_WALK) && !walk_end) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (i_word_index[0]) begin
                r_mem_odd[i_map_select][wr_addr] <= i_word_value;
            end else begin
                r_mem_even[i_map_select][wr_addr] <= i_word_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_even <= r_mem_even[rd_sel][rd_addr];
            r_odd  <= r_mem_odd[rd_sel][rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pair      <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop a taken result unless the final cycle refills the register now
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_operation == OP_XLATE)) begin
                        r_sel    <= i_map_select;
                        r_sector <= i_byte_address[31:SECTOR_SHIFT];
                        r_pair   <= PAIR_W'(1);
                        r_first  <= 1'b1;
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    // Evaluate the pair fetched last cycle, fetch the next one unless the walk ends
                    r_first <= 1'b0;
                    if (walk_take) begin
                        r_sd_base  <= r_odd;
                        r_log_base <= r_even;
                    end
                    if (walk_end) begin
                        r_state <= S_FIN;
                    end else begin
                        r_pair <= r_pair + PAIR_W'(1);
                    end
                end
                S_FIN: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_sd_base + (sector32 - r_log_base);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_xlate_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_XLATE)) |=> (r_state == S_WALK))
        else $error("translate item did not start a walk");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_LOAD)) |=> !$rose(r_out_valid))
        else $error("load item produced a result");

    a_pair_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((32'(r_pair) <= 32'(NPAIRS)) && (r_pair != '0)))
        else $error("pair counter out of range");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the final cycle");
`endif

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import cmst_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 40;       // a full 32-pair walk plus issue and result cycles
    localparam int TOTAL_ITEMS = 1550;
    localparam int MAP_PAIRS   = MAP_WORDS_DEF / 2;

    // Predicts sd_sector for each accepted translate from its own copy of both maps.
    class sector_scoreboard;
        bit [31:0]   map_words [2 * MAP_WORDS_DEF];  // save map first, then ROM map
        bit [31:0]   pending_sectors [$];
        int unsigned errors;

        function bit [31:0] word_at(bit sel, int idx);
            return map_words[sel * MAP_WORDS_DEF + idx];
        endfunction

        function bit [31:0] predict_sd_sector(bit sel, bit [31:0] addr);
            bit [31:0] sector;
            bit [31:0] log_base;
            bit [31:0] sd_base;
            sector   = addr >> SECTOR_SHIFT;
            log_base = word_at(sel, 0);
            sd_base  = word_at(sel, 1);
            // Keep the last pair below the sector, in walk order, up to the end marker.
            for (int p = 0; p + 1 < MAP_WORDS_DEF; p += 2) begin
                if (word_at(sel, p) == END_MARK)
                    break;
                if (word_at(sel, p) < sector) begin
                    log_base = word_at(sel, p);
                    sd_base  = word_at(sel, p + 1);
                end
            end
            return sd_base + (sector - log_base);
        endfunction

        function void note_item(bit op, bit sel, bit [5:0] idx, bit [31:0] val,
                                bit [31:0] addr);
            if (op == OP_LOAD) begin
                if (idx < MAP_WORDS_DEF)
                    map_words[sel * MAP_WORDS_DEF + idx] = val;
            end else begin
                pending_sectors.push_back(predict_sd_sector(sel, addr));
            end
        endfunction

        function void check_result(logic [31:0] got);
            bit [31:0] want;
            if (pending_sectors.size() == 0) begin
                $error("sd_sector: no translate pending, got %h", got);
                errors++;
                return;
            end
            want = pending_sectors.pop_front();
            if (got !== want) begin
                $error("sd_sector: expected %h, got %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_operation    = 1'b0;
    logic        i_map_select   = 1'b0;
    logic [5:0]  i_word_index   = 6'd0;
    logic [31:0] i_word_value   = 32'd0;
    logic [31:0] i_byte_address = 32'd0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_sd_sector;

    sector_scoreboard sb;
    int unsigned      cycle_count    = 0;
    int unsigned      items_sent     = 0;
    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;

    cluster_map_sector_translate_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_map_select   (i_map_select),
        .i_word_index   (i_word_index),
        .i_word_value   (i_word_value),
        .i_byte_address (i_byte_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sd_sector    (o_sd_sector)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Check each result taken at this edge, then pick the ready for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_sd_sector);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // Present one item and hold it until the block takes it.
    task automatic send_item(bit op, bit sel, bit [5:0] idx, bit [31:0] val,
                             bit [31:0] addr);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_map_select   <= sel;
        i_word_index   <= idx;
        i_word_value   <= val;
        i_byte_address <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(op, sel, idx, val, addr);
        items_sent++;
    endtask

    task automatic load_word(bit sel, int idx, bit [31:0] val);
        send_item(OP_LOAD, sel, 6'(idx), val, $urandom());
    endtask

    task automatic translate_addr(bit sel, bit [31:0] addr);
        send_item(OP_XLATE, sel, 6'($urandom_range(63)), $urandom(), addr);
    endtask

    // Stop sending and wait for every outstanding translate to come back.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_sectors.size() != 0);
    endtask

    task automatic run_directed();
        // Pair 0 then end marker: below, equal to and above the start, plus the top address.
        load_word(MAP_SAVE, 0, 32'd10);
        load_word(MAP_SAVE, 1, 32'd1000);
        load_word(MAP_SAVE, 2, END_MARK);
        load_word(MAP_SAVE, 3, 32'd0);
        translate_addr(MAP_SAVE, 32'd0);
        translate_addr(MAP_SAVE, 32'd10 << SECTOR_SHIFT);
        translate_addr(MAP_SAVE, (32'd11 << SECTOR_SHIFT) | 32'h1FF);
        translate_addr(MAP_SAVE, 32'hFFFF_FFFF);
        // End marker already in word 0: pair 0 still used, result wraps.
        load_word(MAP_ROM, 0, END_MARK);
        load_word(MAP_ROM, 1, 32'hFFFF_FFFF);
        translate_addr(MAP_ROM, 32'h0000_0200);
        translate_addr(MAP_ROM, 32'hFFFF_FFFF);
        load_word(MAP_ROM, 63, 32'd0);
        // Unsorted starts: the later, smaller start wins; SD start wraps past 2^32.
        load_word(MAP_SAVE, 4, END_MARK);
        load_word(MAP_SAVE, 5, 32'd0);
        load_word(MAP_SAVE, 2, 32'd5);
        load_word(MAP_SAVE, 3, 32'hFFFF_FFFF);
        translate_addr(MAP_SAVE, 32'd12 << SECTOR_SHIFT);
        translate_addr(MAP_SAVE, 32'd7 << SECTOR_SHIFT);
        translate_addr(MAP_SAVE, 32'd3 << SECTOR_SHIFT);
    endtask

    // Write a map of the given number of pairs, closed by an end marker when it is short.
    task automatic build_map(bit sel, int pairs);
        bit [31:0] start;
        bit        ascending;
        ascending = ($urandom_range(99) < 75);
        start     = 32'($urandom_range(4096));
        for (int k = 0; k < pairs; k++) begin
            if (ascending) begin
                start = start + 32'($urandom_range(32'h40000, 1));
            end else begin
                case ($urandom_range(3))
                    0:       start = 32'($urandom_range(32'h7F_FFFF));
                    1:       start = $urandom();
                    2:       start = 32'd0;
                    default: start = END_MARK - 32'd1;
                endcase
            end
            load_word(sel, 2 * k, start);
            load_word(sel, 2 * k + 1, $urandom());
        end
        if (pairs < MAP_PAIRS) begin
            load_word(sel, 2 * pairs, END_MARK);
            load_word(sel, 2 * pairs + 1, $urandom());
        end
    endtask

    // Aim most addresses at or next to a start word so pair boundaries get hit.
    task automatic translate_burst(bit sel);
        bit [31:0] sector;
        bit [31:0] addr;
        int        count;
        int        mode;
        count = $urandom_range(12, 1);
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(99);
            if (mode < 55) begin
                sector = sb.word_at(sel, 2 * $urandom_range(MAP_PAIRS - 1))
                         + 32'($urandom_range(2)) - 32'd1;
                addr = {sector[22:0], 9'($urandom_range(511))};
            end else if (mode < 70) begin
                addr = $urandom();
            end else if (mode < 80) begin
                addr = 32'($urandom_range(511));
            end else if (mode < 90) begin
                addr = {23'h7F_FFFF, 9'($urandom_range(511))};
            end else begin
                addr = 32'($urandom_range(32'h1000)) << SECTOR_SHIFT;
            end
            translate_addr(sel, addr);
        end
    endtask

    task automatic random_step();
        int pick;
        int pairs;
        bit sel;
        pick = $urandom_range(99);
        sel  = 1'($urandom_range(1));
        if (pick < 8) begin
            pairs = $urandom_range(99);
            if (pairs < 60)
                pairs = $urandom_range(6, 1);
            else if (pairs < 90)
                pairs = $urandom_range(MAP_PAIRS - 1, 7);
            else
                pairs = MAP_PAIRS;
            build_map(sel, pairs);
        end else if (pick < 85) begin
            translate_burst(sel);
        end else begin
            // Stray writes anywhere, some of them end markers.
            repeat ($urandom_range(3, 1))
                load_word(1'($urandom_range(1)), $urandom_range(63),
                          ($urandom_range(3) == 0) ? END_MARK : $urandom());
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        // Fill every word of both maps so no walk can reach an unwritten entry.
        build_map(MAP_SAVE, MAP_PAIRS);
        build_map(MAP_ROM, MAP_PAIRS);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            while (items_sent < TOTAL_ITEMS * (ph + 1) / 4)
                random_step();
            wait_results_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_sectors.size() != 0) begin
            $error("sd_sector: %0d results never arrived", sb.pending_sectors.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
